[rtl/ihq_pkg.sv]
`timescale 1ns / 1ps

package ihq_pkg;

   localparam int NEURON_W = 10;
   localparam int NEURON_SPAN = 1 << NEURON_W;
   localparam int CMD_W = 2;
   localparam int STATUS_W = 2;
   localparam int TIME_IO_W = 32;
   localparam int COUNT_W = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_POP    = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE   = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_REJECT = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_CLEAR  = 10'b0000000010,
      S_LOOKUP = 10'b0000000100,
      S_ROOT   = 10'b0000001000,
      S_LAST   = 10'b0000010000,
      S_UP     = 10'b0000100000,
      S_DN_L   = 10'b0001000000,
      S_DN_R   = 10'b0010000000,
      S_PLACE  = 10'b0100000000,
      S_FINISH = 10'b1000000000
   } state_type;

   typedef struct packed {
      status_type            status;
      logic [NEURON_W-1:0]   out_neuron;
      logic [TIME_IO_W-1:0]  out_time;
      logic [COUNT_W-1:0]    queue_count;
   } result_type;

endpackage

[rtl/ihq_ram.sv]
`timescale 1ns / 1ps

module ihq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ihq_ctrl.sv]
`timescale 1ns / 1ps

module ihq_ctrl
   import ihq_pkg::*;
#(
   parameter int MAX_NEURONS = 1024,
   parameter int TIME_BITS = 32,
   localparam int EW = TIME_BITS + NEURON_W,
   localparam int HW = $clog2(MAX_NEURONS),
   localparam int PW = $clog2(MAX_NEURONS + 1),
   localparam int MAP_DEPTH = (MAX_NEURONS < NEURON_SPAN) ? MAX_NEURONS : NEURON_SPAN,
   localparam int MW = $clog2(MAP_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_fire,
   input  cmd_type              cmd,
   input  logic [NEURON_W-1:0]  neuron,
   input  logic [TIME_IO_W-1:0] event_time,
   output logic                 cmd_ready,
   input  logic                 res_ready,
   output logic                 res_valid,
   output result_type           res,
   output logic                 heap_we,
   output logic [HW-1:0]        heap_waddr,
   output logic [EW-1:0]        heap_wdata,
   output logic [HW-1:0]        heap_raddr,
   input  logic [EW-1:0]        heap_rdata,
   output logic                 map_we,
   output logic [MW-1:0]        map_waddr,
   output logic [PW-1:0]        map_wdata,
   output logic [MW-1:0]        map_raddr,
   input  logic [PW-1:0]        map_rdata
);

   localparam int XW = HW + 2;
   localparam logic [PW-1:0] MISSING = PW'(MAX_NEURONS);

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [NEURON_W-1:0]  nrn_ff, nrn_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [EW-1:0]        ent_ff, ent_in;
   logic [EW-1:0]        lft_ff, lft_in;
   logic [HW-1:0]        bidx_ff, bidx_in;
   logic [HW-1:0]        pos_ff, pos_in;
   logic [PW-1:0]        cnt_ff, cnt_in;
   logic                 moved_ff, moved_in;
   status_type           status_ff, status_in;
   logic [NEURON_W-1:0]  on_ff, on_in;
   logic [TIME_IO_W-1:0] ot_ff, ot_in;
   logic [MW-1:0]        clr_ff, clr_in;

   logic                 nrn_bad;
   logic [HW-1:0]        par1, par2;
   logic [HW:0]          left_p;
   logic [PW-1:0]        last;
   logic [EW-1:0]        new_ent;
   logic [EW-1:0]        best;
   logic [HW-1:0]        best_idx;
   logic [HW:0]          left_b;

   assign nrn_bad = 32'(nrn_ff) >= MAX_NEURONS;
   assign par1    = HW'((pos_ff - 1'b1) >> 1);
   assign par2    = HW'((par1 - 1'b1) >> 1);
   assign left_p  = {pos_ff, 1'b1};
   assign last    = cnt_ff - 1'b1;
   assign new_ent = {time_ff, nrn_ff};
   assign left_b  = {best_idx, 1'b1};

   always_comb begin
      if (state_ff == S_DN_R && heap_rdata < lft_ff) begin
         best     = heap_rdata;
         best_idx = bidx_ff + 1'b1;
      end else if (state_ff == S_DN_R) begin
         best     = lft_ff;
         best_idx = bidx_ff;
      end else begin
         best     = heap_rdata;
         best_idx = left_p[HW-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      nrn_in     = nrn_ff;
      time_in    = time_ff;
      ent_in     = ent_ff;
      lft_in     = lft_ff;
      bidx_in    = bidx_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      moved_in   = moved_ff;
      status_in  = status_ff;
      on_in      = on_ff;
      ot_in      = ot_ff;
      clr_in     = clr_ff;
      heap_we    = 1'b0;
      heap_waddr = pos_ff;
      heap_wdata = ent_ff;
      heap_raddr = '0;
      map_we     = 1'b0;
      map_waddr  = ent_ff[MW-1:0];
      map_wdata  = PW'(pos_ff);
      map_raddr  = neuron[MW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = MISSING;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == MW'(MAP_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_fire) begin
               cmd_in    = cmd;
               nrn_in    = neuron;
               time_in   = TIME_BITS'(event_time);
               status_in = ST_DONE;
               on_in     = '0;
               ot_in     = '0;
               moved_in  = 1'b0;
               unique case (cmd)
                  CMD_ADD, CMD_REMOVE: state_in = S_LOOKUP;
                  CMD_POP: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_ROOT;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_LOOKUP: begin
            if (cmd_ff == CMD_ADD) begin
               if (nrn_bad || map_rdata != MISSING || cnt_ff == MISSING) begin
                  status_in = ST_REJECT;
                  state_in  = S_FINISH;
               end else begin
                  ent_in = new_ent;
                  pos_in = cnt_ff[HW-1:0];
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_ff == '0) begin
                     heap_we    = 1'b1;
                     heap_waddr = '0;
                     heap_wdata = new_ent;
                     map_we     = 1'b1;
                     map_waddr  = nrn_ff[MW-1:0];
                     map_wdata  = '0;
                     state_in   = S_FINISH;
                  end else begin
                     heap_raddr = HW'((cnt_ff[HW-1:0] - 1'b1) >> 1);
                     state_in   = S_UP;
                  end
               end
            end else begin
               if (nrn_bad || map_rdata >= cnt_ff) begin
                  status_in = ST_ABSENT;
                  state_in  = S_FINISH;
               end else begin
                  map_we     = 1'b1;
                  map_waddr  = nrn_ff[MW-1:0];
                  map_wdata  = MISSING;
                  cnt_in     = last;
                  pos_in     = map_rdata[HW-1:0];
                  heap_raddr = last[HW-1:0];
                  state_in   = (map_rdata == last) ? S_FINISH : S_LAST;
               end
            end
         end
         S_ROOT: begin
            on_in      = heap_rdata[NEURON_W-1:0];
            ot_in      = TIME_IO_W'(heap_rdata[EW-1:NEURON_W]);
            map_we     = 1'b1;
            map_waddr  = heap_rdata[MW-1:0];
            map_wdata  = MISSING;
            cnt_in     = last;
            pos_in     = '0;
            heap_raddr = last[HW-1:0];
            state_in   = (last == '0) ? S_FINISH : S_LAST;
         end
         S_LAST: begin
            ent_in = heap_rdata;
            if (pos_ff == '0) begin
               if (XW'(left_p) < XW'(cnt_ff)) begin
                  heap_raddr = left_p[HW-1:0];
                  state_in   = S_DN_L;
               end else begin
                  heap_we    = 1'b1;
                  heap_wdata = heap_rdata;
                  map_we     = 1'b1;
                  map_waddr  = heap_rdata[MW-1:0];
                  state_in   = S_FINISH;
               end
            end else begin
               heap_raddr = par1;
               state_in   = S_UP;
            end
         end
         S_UP: begin
            if (ent_ff < heap_rdata) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rdata;
               map_we     = 1'b1;
               map_waddr  = heap_rdata[MW-1:0];
               pos_in     = par1;
               moved_in   = 1'b1;
               heap_raddr = par2;
               state_in   = (par1 == '0) ? S_PLACE : S_UP;
            end else if (moved_ff || cmd_ff == CMD_ADD ||
                         XW'(left_p) >= XW'(cnt_ff)) begin
               heap_we  = 1'b1;
               map_we   = 1'b1;
               state_in = S_FINISH;
            end else begin
               heap_raddr = left_p[HW-1:0];
               state_in   = S_DN_L;
            end
         end
         S_DN_L, S_DN_R: begin
            if (state_ff == S_DN_L && XW'(left_p) + 1'b1 < XW'(cnt_ff)) begin
               lft_in     = heap_rdata;
               bidx_in    = left_p[HW-1:0];
               heap_raddr = HW'(left_p + 1'b1);
               state_in   = S_DN_R;
            end else if (best < ent_ff) begin
               heap_we    = 1'b1;
               heap_wdata = best;
               map_we     = 1'b1;
               map_waddr  = best[MW-1:0];
               pos_in     = best_idx;
               heap_raddr = left_b[HW-1:0];
               state_in   = (XW'(left_b) < XW'(cnt_ff)) ? S_DN_L : S_PLACE;
            end else begin
               heap_we  = 1'b1;
               map_we   = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_PLACE: begin
            heap_we  = 1'b1;
            map_we   = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         clr_ff   <= clr_in;
      end
      cmd_ff    <= cmd_in;
      nrn_ff    <= nrn_in;
      time_ff   <= time_in;
      ent_ff    <= ent_in;
      lft_ff    <= lft_in;
      bidx_ff   <= bidx_in;
      pos_ff    <= pos_in;
      moved_ff  <= moved_in;
      status_ff <= status_in;
      on_ff     <= on_in;
      ot_ff     <= ot_in;
   end

   assign cmd_ready = state_ff == S_IDLE;
   assign res_valid = state_ff == S_FINISH;
   assign res       = '{status: status_ff, out_neuron: on_ff, out_time: ot_ff,
                        queue_count: COUNT_W'(cnt_ff)};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MISSING) else $error("heap count above capacity");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !heap_we && !cmd_ready) else $error("activity during clear");
   a_write_inside: assert property (@(posedge clock) disable iff (reset)
      heap_we |-> PW'(heap_waddr) < cnt_in) else $error("heap write beyond count");
   a_finish_leave: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && res_ready |=> state_ff == S_IDLE)
      else $error("result handed over but sequencer stuck");
`endif

endmodule

[rtl/indexed_min_heap_event_queue_core.sv]
`timescale 1ns / 1ps
// Channel   Dir  Transfer on              tuser       tdata (lowest bit up)
// req       in   req_tvalid & req_tready  cmd [1:0]   neuron[9:0], event_time[41:10]
// rsp       out  rsp_tvalid & rsp_tready  status[1:0] out_neuron[9:0], out_time[41:10],
//                                                     queue_count[52:42]
//
// One command at a time. Add climbs level by level from the new leaf. Remove and
// pop refill the freed slot with the last entry, which climbs or descends level by
// level, each step paced by the single read port of the heap memory, which serves
// each parent and child read in turn.
// After reset a clearing pass over min(MAX_NEURONS,1024) map entries marks every
// neuron missing in the position map; req_tready stays low meanwhile.
// A result waits in the output register while the next command is taken;
// that command finishes only once the register has been emptied.

module indexed_min_heap_event_queue_core
   import ihq_pkg::*;
#(
   parameter int MAX_NEURONS = 1024,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [47:0] req_tdata,   // neuron, event_time, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [55:0] rsp_tdata    // out_neuron, out_time, queue_count, zero fill
);

   localparam int EW = TIME_BITS + NEURON_W;
   localparam int HW = $clog2(MAX_NEURONS);
   localparam int PW = $clog2(MAX_NEURONS + 1);
   localparam int MAP_DEPTH = (MAX_NEURONS < NEURON_SPAN) ? MAX_NEURONS : NEURON_SPAN;
   localparam int MW = $clog2(MAP_DEPTH);

   logic          req_fire;
   logic          res_ready;
   logic          res_valid;
   result_type    res;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          heap_we;
   logic [HW-1:0] heap_waddr, heap_raddr;
   logic [EW-1:0] heap_wdata, heap_rdata;
   logic          map_we;
   logic [MW-1:0] map_waddr, map_raddr;
   logic [PW-1:0] map_wdata, map_rdata;

   assign req_fire = req_tvalid && req_tready;
   // the output register is free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   // heap entries: {time, neuron}, so one unsigned compare orders by time then neuron
   ihq_ram #(.WIDTH(EW), .DEPTH(MAX_NEURONS)) u_heap (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata)
   );

   // position map: neuron to heap slot, MAX_NEURONS meaning missing
   ihq_ram #(.WIDTH(PW), .DEPTH(MAP_DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   ihq_ctrl #(.MAX_NEURONS(MAX_NEURONS), .TIME_BITS(TIME_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cmd_fire   (req_fire),
      .cmd        (cmd_type'(req_tuser)),
      .neuron     (req_tdata[9:0]),
      .event_time (req_tdata[41:10]),
      .cmd_ready  (req_tready),
      .res_ready  (res_ready),
      .res_valid  (res_valid),
      .res        (res),
      .heap_we    (heap_we),
      .heap_waddr (heap_waddr),
      .heap_wdata (heap_wdata),
      .heap_raddr (heap_raddr),
      .heap_rdata (heap_rdata),
      .map_we     (map_we),
      .map_waddr  (map_waddr),
      .map_wdata  (map_wdata),
      .map_raddr  (map_raddr),
      .map_rdata  (map_rdata)
   );

   // load a finished result when the register is free, drop it on transfer
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {3'b000, rsp_ff.queue_count, rsp_ff.out_time, rsp_ff.out_neuron};

endmodule
